FILE: rtl/pce_pkg.sv
package pce_pkg;

    // Effect mode codes
    localparam logic [2:0] MODE_PASS   = 3'd0;
    localparam logic [2:0] MODE_SEPIA  = 3'd1;
    localparam logic [2:0] MODE_GRAY   = 3'd2;
    localparam logic [2:0] MODE_BRIGHT = 3'd3;
    localparam logic [2:0] MODE_SWAP   = 3'd4;

    // Register indexes (byte address = 4 * index)
    localparam logic REG_EFFECT_MODE = 1'b0;
    localparam logic REG_BRIGHTNESS  = 1'b1;

    localparam int AddrWidth = 3;

    // Sepia weights, thousandths
    localparam logic [9:0] SEPIA_RR = 10'd393;
    localparam logic [9:0] SEPIA_RG = 10'd769;
    localparam logic [9:0] SEPIA_RB = 10'd189;
    localparam logic [9:0] SEPIA_GR = 10'd349;
    localparam logic [9:0] SEPIA_GG = 10'd686;
    localparam logic [9:0] SEPIA_GB = 10'd168;
    localparam logic [9:0] SEPIA_BR = 10'd272;
    localparam logic [9:0] SEPIA_BG = 10'd534;
    localparam logic [9:0] SEPIA_BB = 10'd131;

    // Luma weights, thousandths (sum to 1000)
    localparam logic [9:0] LUMA_R = 10'd299;
    localparam logic [9:0] LUMA_G = 10'd587;
    localparam logic [9:0] LUMA_B = 10'd114;

    // Weighted sums are below 2^19; sums from 256000 up saturate to 255
    localparam logic [18:0] SAT_LIMIT = 19'd256000;

    // x / 1000 as (x * ceil(2^28 / 1000)) >> 28, exact for x < 256000
    localparam int          RecipShift = 28;
    localparam logic [18:0] RECIP_1000 = 19'd268436;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_pix_out;

    typedef struct packed {
        logic [2:0] effect_mode;
        logic [7:0] brightness_offset;
    } t_cfg;

endpackage

FILE: rtl/pce_apb_regs.sv
module pce_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pce_pkg::AddrWidth-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output pce_pkg::t_cfg                 o_cfg
);

    logic [2:0] r_mode;
    logic [7:0] r_offset;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= pce_pkg::MODE_PASS;
            r_offset <= 8'd0;
        end else if (wr_en) begin
            unique case (paddr[2])
                pce_pkg::REG_EFFECT_MODE: r_mode   <= pwdata[2:0];
                pce_pkg::REG_BRIGHTNESS:  r_offset <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (paddr[2])
            pce_pkg::REG_EFFECT_MODE: prdata = {29'd0, r_mode};
            pce_pkg::REG_BRIGHTNESS:  prdata = {24'd0, r_offset};
            default:                  prdata = 32'd0;
        endcase
    end

    assign o_cfg.effect_mode       = r_mode;
    assign o_cfg.brightness_offset = r_offset;

endmodule

FILE: rtl/pce_effect_alu.sv
module pce_effect_alu (
    input  pce_pkg::t_cfg     i_cfg,
    input  pce_pkg::t_pix_in  i_pix,
    output pce_pkg::t_pix_out o_pix
);

    // Three-term weighted sum, fits 19 bits
    function automatic logic [18:0] wsum(input logic [9:0] wr, input logic [9:0] wg,
                                         input logic [9:0] wb, input logic [7:0] r,
                                         input logic [7:0] g, input logic [7:0] b);
        wsum = 19'(wr) * 19'(r) + 19'(wg) * 19'(g) + 19'(wb) * 19'(b);
    endfunction

    // Truncating divide by 1000 with saturation at 255
    function automatic logic [7:0] div_sat(input logic [18:0] s);
        logic [37:0] prod;
        prod = 38'(s) * 38'(pce_pkg::RECIP_1000);
        if (s >= pce_pkg::SAT_LIMIT) begin
            div_sat = 8'hFF;
        end else begin
            div_sat = prod[pce_pkg::RecipShift +: 8];
        end
    endfunction

    // Add offset, clamp at 255
    function automatic logic [7:0] add_sat(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        add_sat = s[8] ? 8'hFF : s[7:0];
    endfunction

    logic [7:0] r, g, b;
    logic [7:0] luma;

    assign r = i_pix.red_in;
    assign g = i_pix.green_in;
    assign b = i_pix.blue_in;

    // Luma never exceeds 255000, so no clamp is hit
    assign luma = div_sat(wsum(pce_pkg::LUMA_R, pce_pkg::LUMA_G, pce_pkg::LUMA_B, r, g, b));

    // Effect select; unused codes pass through
    always_comb begin
        o_pix.red_out   = r;
        o_pix.green_out = g;
        o_pix.blue_out  = b;
        unique case (i_cfg.effect_mode)
            pce_pkg::MODE_SEPIA: begin
                o_pix.red_out   = div_sat(wsum(pce_pkg::SEPIA_RR, pce_pkg::SEPIA_RG,
                                               pce_pkg::SEPIA_RB, r, g, b));
                o_pix.green_out = div_sat(wsum(pce_pkg::SEPIA_GR, pce_pkg::SEPIA_GG,
                                               pce_pkg::SEPIA_GB, r, g, b));
                o_pix.blue_out  = div_sat(wsum(pce_pkg::SEPIA_BR, pce_pkg::SEPIA_BG,
                                               pce_pkg::SEPIA_BB, r, g, b));
            end
            pce_pkg::MODE_GRAY: begin
                o_pix.red_out   = luma;
                o_pix.green_out = luma;
                o_pix.blue_out  = luma;
            end
            pce_pkg::MODE_BRIGHT: begin
                o_pix.red_out   = add_sat(r, i_cfg.brightness_offset);
                o_pix.green_out = add_sat(g, i_cfg.brightness_offset);
                o_pix.blue_out  = add_sat(b, i_cfg.brightness_offset);
            end
            pce_pkg::MODE_SWAP: begin
                o_pix.red_out  = b;
                o_pix.blue_out = r;
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/pixel_color_effect_core.sv
// Per-pixel color effect (pass-through, sepia, grayscale, brighten, red/blue
// swap) on an 8-bit RGB stream. One pixel per clock is sustained while
// i_out_stall is low; an accepted pixel passes through the input register,
// then the result register, with the effect logic between them.
// i_out_stall reaches o_in_stall in the same cycle, but the input register
// keeps taking a beat while a finished result waits, so one extra pixel is
// absorbed per stall. Effect mode and brightness offset are set over the APB
// port (mode at byte 0, offset at byte 4) and must only change while the pipe
// is empty.
module pixel_color_effect_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pce_pkg::t_pix_in              i_in_pix,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pce_pkg::t_pix_out             o_out_pix,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pce_pkg::AddrWidth-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    pce_pkg::t_cfg     cfg;
    pce_pkg::t_pix_out alu_pix;

    logic              r_s1_vld;
    pce_pkg::t_pix_in  r_s1_pix;
    logic              r_out_vld;
    pce_pkg::t_pix_out r_out_pix;
    logic              in_acc;
    logic              s1_adv;

    pce_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pce_effect_alu u_alu (
        .i_cfg (cfg),
        .i_pix (r_s1_pix),
        .o_pix (alu_pix)
    );

    // Handshake: stage 1 moves on when the result register is free or draining
    assign s1_adv     = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix <= i_in_pix;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_vld) begin
            r_out_pix <= alu_pix;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_pix   = r_out_pix;

`ifndef NO_ASSERTIONS
    // A held stage 1 keeps its pixel
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_adv |=> r_s1_vld && $stable(r_s1_pix))
        else $error("stage 1 lost its pixel while held");

    // A pixel leaving stage 1 lands in the result register
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && s1_adv |=> o_out_valid)
        else $error("pixel dropped between stages");

    // Input stalls only when both stages are full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_vld && o_out_valid && i_out_stall)
        else $error("input stalled with room in the pipe");

    // An accepted beat occupies stage 1 next cycle
    a_acc_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_vld)
        else $error("accepted beat not held in stage 1");
`endif

endmodule
